// ----- rtl/software_timer_bank_unit_assert.svh -----
// Assertion macros shared by the timer bank RTL.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define STB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define STB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stb_pkg.sv -----
// Shared types and codes for the software timer bank.
// No dependencies; used by the slot ALU and the top level.
package stb_pkg;

  // Operation codes of the command channel
  localparam logic [2:0] OP_CONFIGURE = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_DESTROY   = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  // Slot lifecycle codes
  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_STOPPED   = 3'd3;
  localparam logic [2:0] ST_DESTROYED = 3'd4;

  // Event kinds of the result channel
  localparam logic [1:0] KIND_ACK       = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_NO_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_INFO      = 2'd3;

  // Fire events reported per tick at most
  localparam logic [3:0] MAX_FIRES = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic       tick_match;
    logic       cmd_cls;
  } alu_ctrl_t;

  typedef struct packed {
    logic wr;
    logic fire;
  } alu_stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        cls;
    logic [31:0] start_delay;
    logic [31:0] period;
    logic [2:0]  state;
  } result_t;

endpackage

// ----- rtl/stb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stb_ram #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/stb_slot_alu.sv -----
// Shared slot update unit: applies one operation to one slot record.
// Holds the single countdown decrementer and zero compare. Uses stb_pkg.
module stb_slot_alu import stb_pkg::*; #(
  parameter int TW = 32
) (
  input  alu_ctrl_t         ctrl,
  input  logic [TW-1:0]     cmd_sd,
  input  logic [TW-1:0]     cmd_per,
  input  logic [TW-1:0]     old_sd,
  input  logic [TW-1:0]     old_per,
  input  logic [TW-1:0]     old_cd,
  input  logic              old_cls,
  input  logic [2:0]        old_state,
  output logic [TW-1:0]     new_sd,
  output logic [TW-1:0]     new_per,
  output logic [TW-1:0]     new_cd,
  output logic              new_cls,
  output logic [2:0]        new_state,
  output alu_stat_t         stat
);

  logic [TW-1:0] cd_dec;
  logic [TW-1:0] cmd_load;
  logic [TW-1:0] old_load;
  logic          expire;

  // Shared decrement and expiry compare
  assign cd_dec   = old_cd - TW'(1);
  assign expire   = (old_cd == '0) || (cd_dec == '0);
  assign cmd_load = (cmd_sd != '0) ? cmd_sd : cmd_per;
  assign old_load = (old_sd != '0) ? old_sd : old_per;

  // Decode the operation into the new slot record
  always_comb begin
    new_sd    = old_sd;
    new_per   = old_per;
    new_cd    = old_cd;
    new_cls   = old_cls;
    new_state = old_state;
    stat      = '0;
    unique case (ctrl.op)
      OP_CONFIGURE: begin
        new_sd    = cmd_sd;
        new_per   = cmd_per;
        new_cls   = ctrl.cmd_cls;
        new_cd    = cmd_load;
        new_state = ST_CREATED;
        stat.wr   = 1'b1;
      end
      OP_START: begin
        if (old_state == ST_CREATED || old_state == ST_STOPPED) begin
          new_cd    = old_load;
          new_state = ST_STARTED;
          stat.wr   = 1'b1;
        end
      end
      OP_STOP: begin
        if (old_state == ST_STARTED) begin
          new_state = ST_STOPPED;
          stat.wr   = 1'b1;
        end
      end
      OP_DESTROY: begin
        new_state = ST_DESTROYED;
        stat.wr   = 1'b1;
      end
      OP_TICK: begin
        if (ctrl.tick_match) begin
          stat.wr   = 1'b1;
          stat.fire = expire;
          if (!expire) begin
            new_cd = cd_dec;
          end else if (old_per != '0) begin
            new_cd = old_per;
          end else begin
            // One-shot: countdown rests at zero, slot drops to stopped
            new_cd    = '0;
            new_state = ST_STOPPED;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/software_timer_bank_unit.sv -----
// Software timer bank: NUM_SLOTS one-shot or periodic timer slots.
// Command channel (cmd_valid/cmd_ready) carries operation, slot, start_delay,
// period and hard_class. Event channel (evt_valid/evt_ready) returns one event
// per command, or one or more per tick, with last set on the final event.
// Commands are taken one at a time: cmd_ready is high only while the
// sequencer is idle. A slot command reads the slot record from the slot RAM,
// updates it in the shared slot ALU and writes it back; the S_READ state reads
// the record and the S_EXEC state loads its event into the output register,
// after which the sequencer returns to idle and cmd_ready rises again.
// A tick walks the slot RAM twice (hard class, then soft class), with a T_READ
// state and a T_EXEC state per slot for the read and the update; its final
// event is loaded in the T_FLUSH state, after which the sequencer goes idle.
// Up to eight fire events are reported in order; a tick with no fire gives
// one no-expiry event.
// The output register lets the next command be accepted while an event still
// waits. When evt_ready stays low, the sequencer holds before the next event
// load and no slot update is lost.
// Reset clears the per-slot written flags, so every slot reads as unused with
// zero settings; the RAM contents themselves are not cleared.
// Uses stb_pkg, stb_ram, stb_slot_alu and software_timer_bank_unit_assert.svh.
`include "software_timer_bank_unit_assert.svh"

module software_timer_bank_unit import stb_pkg::*; #(
  parameter int NUM_SLOTS  = 8,
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  operation,
  input  logic [2:0]  slot,
  input  logic [31:0] start_delay,
  input  logic [31:0] period,
  input  logic        hard_class,
  output logic        evt_valid,
  input  logic        evt_ready,
  output logic [1:0]  event_kind,
  output logic [2:0]  event_slot,
  output logic        info_class,
  output logic [31:0] info_start_delay,
  output logic [31:0] info_period,
  output logic [2:0]  state_code,
  output logic        last
);

  localparam int TW       = TICK_WIDTH;
  localparam int IW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RW       = 3 * TW + 4;
  localparam logic [6:0]    NSLOT    = 7'(NUM_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    T_READ  = 6'b001000,
    T_EXEC  = 6'b010000,
    T_FLUSH = 6'b100000
  } seq_state_t;

  seq_state_t state, state_next;

  // Latched command
  logic [2:0]    op_q;
  logic [2:0]    slot_q;
  logic [TW-1:0] sd_q;
  logic [TW-1:0] per_q;
  logic          cls_q;

  // Tick walk
  logic [IW-1:0] idx;
  logic          pass;
  logic [3:0]    fire_cnt;
  result_t       pend;
  logic          pend_valid;

  // Slot storage
  logic [NUM_SLOTS-1:0] written;
  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_raddr, rd_addr_q;
  logic [RW-1:0]        ram_rdata, ram_wdata, rec;

  // ALU interface
  alu_ctrl_t     ctrl;
  alu_stat_t     stat;
  logic [TW-1:0] new_sd, new_per, new_cd;
  logic          new_cls;
  logic [2:0]    new_state;
  logic [2:0]    old_state;
  logic          old_cls;

  // Output register
  result_t out_res;
  logic    out_last;
  logic    emit;
  logic    out_load;
  result_t load_res;
  logic    load_last;

  logic          in_range, cmd_ok, accept, can_report, tick_stall, advance;
  logic [6:0]    slot_ext, idx_ext;
  logic [IW-1:0] slot_addr;
  logic [63:0]   sd_wide, per_wide;
  result_t       new_res;

  assign accept    = cmd_valid && cmd_ready;
  assign cmd_ready = (state == S_IDLE);
  assign emit      = !evt_valid || evt_ready;

  assign slot_ext  = {4'b0000, slot_q};
  assign in_range  = slot_ext < NSLOT;
  assign cmd_ok    = in_range && (op_q <= OP_QUERY);
  assign slot_addr = in_range ? slot_ext[IW-1:0] : '0;
  assign idx_ext   = 7'(idx);

  // Record read back; a never-written slot reads as all zero
  assign rec       = written[rd_addr_q] ? ram_rdata : '0;
  assign old_cls   = rec[3*TW];
  assign old_state = rec[3*TW+3:3*TW+1];
  assign ram_wdata = {new_state, new_cls, new_cd, new_per, new_sd};

  assign ctrl.op         = (state == T_EXEC) ? OP_TICK : op_q;
  assign ctrl.tick_match = (old_state == ST_STARTED) && (old_cls == !pass);
  assign ctrl.cmd_cls    = cls_q;

  stb_slot_alu #(.TW(TW)) u_alu (
    .ctrl      (ctrl),
    .cmd_sd    (sd_q),
    .cmd_per   (per_q),
    .old_sd    (rec[TW-1:0]),
    .old_per   (rec[2*TW-1:TW]),
    .old_cd    (rec[3*TW-1:2*TW]),
    .old_cls   (old_cls),
    .old_state (old_state),
    .new_sd    (new_sd),
    .new_per   (new_per),
    .new_cd    (new_cd),
    .new_cls   (new_cls),
    .new_state (new_state),
    .stat      (stat)
  );

  stb_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS), .AW(IW)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Event fields from the updated record
  assign sd_wide             = 64'(new_sd);
  assign per_wide            = 64'(new_per);
  assign new_res.kind        = (state == T_EXEC) ? KIND_FIRED :
                               ((op_q == OP_QUERY) ? KIND_INFO : KIND_ACK);
  assign new_res.slot        = (state == T_EXEC) ? idx_ext[2:0] : slot_q;
  assign new_res.cls         = cmd_ok || (state == T_EXEC) ? new_cls : 1'b0;
  assign new_res.start_delay = cmd_ok || (state == T_EXEC) ? sd_wide[31:0] : '0;
  assign new_res.period      = cmd_ok || (state == T_EXEC) ? per_wide[31:0] : '0;
  assign new_res.state       = cmd_ok || (state == T_EXEC) ? new_state : ST_UNUSED;

  assign can_report = fire_cnt < MAX_FIRES;
  assign tick_stall = stat.fire && can_report && pend_valid && !emit;

  // Sequencer and datapath control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = slot_addr;
    out_load   = 1'b0;
    load_res   = new_res;
    load_last  = 1'b1;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_TICK) ? T_READ : S_READ;
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (emit) begin
          ram_we     = cmd_ok && stat.wr;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      T_READ: begin
        ram_re     = 1'b1;
        ram_raddr  = idx;
        state_next = T_EXEC;
      end
      T_EXEC: begin
        if (!tick_stall) begin
          ram_we    = stat.wr;
          advance   = 1'b1;
          // Push the previous fire out; it is not the final event
          out_load  = stat.fire && can_report && pend_valid;
          load_res  = pend;
          load_last = 1'b0;
          state_next = (idx == LAST_IDX && pass) ? T_FLUSH : T_READ;
        end
      end
      T_FLUSH: begin
        if (emit) begin
          out_load = 1'b1;
          if (pend_valid) begin
            load_res = pend;
          end else begin
            load_res      = '0;
            load_res.kind = KIND_NO_EXPIRY;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      written    <= '0;
      evt_valid  <= 1'b0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
      idx        <= '0;
      pass       <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        written[rd_addr_q] <= 1'b1;
      end
      if (out_load) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
      if (accept) begin
        idx        <= '0;
        pass       <= 1'b0;
        fire_cnt   <= '0;
        pend_valid <= 1'b0;
      end
      if (advance) begin
        if (stat.fire && can_report) begin
          pend_valid <= 1'b1;
          fire_cnt   <= fire_cnt + 4'd1;
        end
        if (idx == LAST_IDX) begin
          idx  <= '0;
          pass <= 1'b1;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      if (state == T_FLUSH && emit) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      slot_q <= slot;
      sd_q   <= TW'(start_delay);
      per_q  <= TW'(period);
      cls_q  <= hard_class;
    end
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
    end
    if (advance && stat.fire && can_report) begin
      pend <= new_res;
    end
    if (out_load) begin
      out_res  <= load_res;
      out_last <= load_last;
    end
  end

  assign event_kind       = out_res.kind;
  assign event_slot       = out_res.slot;
  assign info_class       = out_res.cls;
  assign info_start_delay = out_res.start_delay;
  assign info_period      = out_res.period;
  assign state_code       = out_res.state;
  assign last             = out_last;

  `STB_ASSERT_NOW(a_idle_no_pending, clk, rst, state == S_IDLE, !pend_valid, "pending fire left while idle")
  `STB_ASSERT_NOW(a_fire_count_bound, clk, rst, 1'b1, fire_cnt <= MAX_FIRES, "fire count above limit")
  `STB_ASSERT_NEXT(a_flush_ends_item, clk, rst, state == T_FLUSH && emit, evt_valid && last, "tick did not end with last event")
  `STB_ASSERT_NOW(a_write_in_exec, clk, rst, ram_we, state == S_EXEC || state == T_EXEC, "slot write outside update step")

endmodule
